>>> hdl/tbo_pkg.sv
// types and constants shared by the triangle/box overlap pipeline
package tbo_pkg;

   localparam int COORD_W = 32;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int NUM_AXES = 3;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   // one edge normal and everything projected onto it, relative to the edge start
   typedef struct packed {
      diff_type ux;
      diff_type uy;
      diff_type x0;
      diff_type x1;
      diff_type y0;
      diff_type y1;
      diff_type tx;
      diff_type ty;
   } axis_in_type;

   // register load enables handed from the pipeline control to the axis units
   typedef struct packed {
      logic load_mul;
      logic load_sum;
   } pipe_en_type;

endpackage

>>> hdl/tbo_axis_unit.sv
// one separating-axis test: products, interval bounds and the final interval compare
module tbo_axis_unit (
   input  logic                  clock,
   input  tbo_pkg::pipe_en_type  pipe_en,
   input  tbo_pkg::axis_in_type  axis_in,
   output logic                  axis_ok
);
   import tbo_pkg::*;

   prod_type px0_ff, px1_ff, py0_ff, py1_ff, ptx_ff, pty_ff;
   prod_type px0_in, px1_in, py0_in, py1_in, ptx_in, pty_in;
   sum_type  mn_ff, mx_ff, t_ff;
   sum_type  mn_in, mx_in, t_in;
   prod_type mnx, mxx, mny, mxy;
   sum_type  tmin, tmax;

   // product stage
   always_comb begin
      px0_in = prod_type'(axis_in.ux) * prod_type'(axis_in.x0);
      px1_in = prod_type'(axis_in.ux) * prod_type'(axis_in.x1);
      py0_in = prod_type'(axis_in.uy) * prod_type'(axis_in.y0);
      py1_in = prod_type'(axis_in.uy) * prod_type'(axis_in.y1);
      ptx_in = prod_type'(axis_in.ux) * prod_type'(axis_in.tx);
      pty_in = prod_type'(axis_in.uy) * prod_type'(axis_in.ty);
   end

   always_ff @(posedge clock) begin
      if (pipe_en.load_mul) begin
         px0_ff <= px0_in;
         px1_ff <= px1_in;
         py0_ff <= py0_in;
         py1_ff <= py1_in;
         ptx_ff <= ptx_in;
         pty_ff <= pty_in;
      end
   end

   // corner dot products are separable, so min/max over four corners is
   // the sum of the per-coordinate min/max
   always_comb begin
      mnx   = (px0_ff < px1_ff) ? px0_ff : px1_ff;
      mxx   = (px0_ff < px1_ff) ? px1_ff : px0_ff;
      mny   = (py0_ff < py1_ff) ? py0_ff : py1_ff;
      mxy   = (py0_ff < py1_ff) ? py1_ff : py0_ff;
      mn_in = sum_type'(mnx) + sum_type'(mny);
      mx_in = sum_type'(mxx) + sum_type'(mxy);
      t_in  = sum_type'(ptx_ff) + sum_type'(pty_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en.load_sum) begin
         mn_ff <= mn_in;
         mx_ff <= mx_in;
         t_ff  <= t_in;
      end
   end

   // triangle interval spans the edge start (zero) and the opposite vertex
   always_comb begin
      tmin    = t_ff[SUM_W-1] ? t_ff : '0;
      tmax    = t_ff[SUM_W-1] ? '0 : t_ff;
      axis_ok = !(tmax < mn_ff) && !(mx_ff < tmin);
   end

endmodule

>>> hdl/triangle_box_overlap_test.sv
// Triangle versus axis-aligned box overlap test, 2D separating axis theorem.
// Takes one request per cycle while the result is not stalled and answers overlaps = 1
// when the triangle and box overlap or touch. An accepted request reaches its result
// through four register stages: stage one registers the 33-bit vertex and box
// differences and the extent checks at the accepting edge, stage two the eighteen
// exact 33x33 products, stage three the projected interval bounds, and the result
// register holds the final compares. A stalled result holds the pipeline in place;
// requests keep entering while any stage has room. All arithmetic is exact.
module triangle_box_overlap_test (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tbo_pkg::coord_type  req_tri_ax,
   input  tbo_pkg::coord_type  req_tri_ay,
   input  tbo_pkg::coord_type  req_tri_bx,
   input  tbo_pkg::coord_type  req_tri_by,
   input  tbo_pkg::coord_type  req_tri_cx,
   input  tbo_pkg::coord_type  req_tri_cy,
   input  tbo_pkg::coord_type  req_box_x_min,
   input  tbo_pkg::coord_type  req_box_x_max,
   input  tbo_pkg::coord_type  req_box_y_min,
   input  tbo_pkg::coord_type  req_box_y_max,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_overlaps
);
   import tbo_pkg::*;

   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic ext1_ff, ext2_ff, ext3_ff, rsp_overlaps_ff;
   logic ext1_in, rsp_overlaps_in;
   logic adv1, adv2, adv3, adv4;
   axis_in_type axis_ff [NUM_AXES];
   axis_in_type axis_in [NUM_AXES];
   logic [NUM_AXES-1:0] axis_ok;
   pipe_en_type pipe_en;
   coord_type min_x, max_x, min_y, max_y;

   function automatic diff_type sub(input coord_type a, input coord_type b);
      sub = diff_type'(a) - diff_type'(b);
   endfunction

   function automatic axis_in_type make_axis(
      input coord_type sx, input coord_type sy,
      input coord_type ex, input coord_type ey,
      input coord_type ox, input coord_type oy,
      input coord_type xl, input coord_type xh,
      input coord_type yl, input coord_type yh);
      axis_in_type r;
      r.ux = sub(sy, ey);
      r.uy = sub(ex, sx);
      r.x0 = sub(xl, sx);
      r.x1 = sub(xh, sx);
      r.y0 = sub(yl, sy);
      r.y1 = sub(yh, sy);
      r.tx = sub(ox, sx);
      r.ty = sub(oy, sy);
      make_axis = r;
   endfunction

   // pipeline flow control
   always_comb begin
      adv4 = !rsp_valid_ff || rsp_ready;
      adv3 = !v3_ff || adv4;
      adv2 = !v2_ff || adv3;
      adv1 = !v1_ff || adv2;
      pipe_en.load_mul = adv2;
      pipe_en.load_sum = adv3;
   end

   assign req_ready    = adv1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overlaps = rsp_overlaps_ff;

   // stage one: extents and differences
   always_comb begin
      min_x = (req_tri_ax < req_tri_bx) ? req_tri_ax : req_tri_bx;
      min_x = (req_tri_cx < min_x) ? req_tri_cx : min_x;
      max_x = (req_tri_ax > req_tri_bx) ? req_tri_ax : req_tri_bx;
      max_x = (req_tri_cx > max_x) ? req_tri_cx : max_x;
      min_y = (req_tri_ay < req_tri_by) ? req_tri_ay : req_tri_by;
      min_y = (req_tri_cy < min_y) ? req_tri_cy : min_y;
      max_y = (req_tri_ay > req_tri_by) ? req_tri_ay : req_tri_by;
      max_y = (req_tri_cy > max_y) ? req_tri_cy : max_y;
      ext1_in = !(min_x > req_box_x_max) && !(max_x < req_box_x_min) &&
                !(min_y > req_box_y_max) && !(max_y < req_box_y_min);
      axis_in[0] = make_axis(req_tri_ax, req_tri_ay, req_tri_bx, req_tri_by,
                             req_tri_cx, req_tri_cy, req_box_x_min, req_box_x_max,
                             req_box_y_min, req_box_y_max);
      axis_in[1] = make_axis(req_tri_bx, req_tri_by, req_tri_cx, req_tri_cy,
                             req_tri_ax, req_tri_ay, req_box_x_min, req_box_x_max,
                             req_box_y_min, req_box_y_max);
      axis_in[2] = make_axis(req_tri_cx, req_tri_cy, req_tri_ax, req_tri_ay,
                             req_tri_bx, req_tri_by, req_box_x_min, req_box_x_max,
                             req_box_y_min, req_box_y_max);
      rsp_overlaps_in = ext3_ff && (&axis_ok);
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ext1_ff <= ext1_in;
         for (int i = 0; i < NUM_AXES; i++) begin
            axis_ff[i] <= axis_in[i];
         end
      end
      if (adv2) begin
         ext2_ff <= ext1_ff;
      end
      if (adv3) begin
         ext3_ff <= ext2_ff;
      end
      if (adv4) begin
         rsp_overlaps_ff <= rsp_overlaps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) rsp_valid_ff <= v3_ff;
      end
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      tbo_axis_unit u_axis (
         .clock   (clock),
         .pipe_en (pipe_en),
         .axis_in (axis_ff[g]),
         .axis_ok (axis_ok[g])
      );
   end

`ifndef SYNTHESIS
   // an accepted request lands in stage one
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted request lost at stage one");

   // a blocked stage keeps its item
   a_hold_s3: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !adv4 |=> v3_ff)
      else $error("stage three dropped an item while stalled");

   // failed extent check can never report overlap
   a_extent: assert property (@(posedge clock) disable iff (reset)
      v3_ff && adv4 && !ext3_ff |=> !rsp_overlaps_ff)
      else $error("overlap reported despite disjoint extents");

   // an empty first stage always takes a request
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_ready)
      else $error("request refused with stage one empty");
`endif

endmodule
